@@ src/fetch_group_former_unit_assert.svh @@
// Assertion macros for the fetch group former checker.
// Expects clk and rst in the scope where a macro is used.
`ifndef FETCH_GROUP_FORMER_UNIT_ASSERT_SVH
`define FETCH_GROUP_FORMER_UNIT_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define FGF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fetch group former: same-cycle check failed");

// check that cons holds in the cycle after ante
`define FGF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fetch group former: next-cycle check failed");

`endif

@@ src/fgf_pkg.sv @@
// Shared types and constants for the fetch group former.
// No dependencies; used by the channel interfaces and the top level.
package fgf_pkg;

  localparam int unsigned PC_W        = 64;
  localparam int unsigned PC_BITS_DEF = 64;
  localparam int unsigned SLOT_W      = 11;
  localparam int unsigned BLOCK_W     = 16;
  localparam int unsigned LOG2_W      = 4;
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned APB_DW      = 32;

  localparam logic [LOG2_W-1:0]  FW_MIN = 4'd1;
  localparam logic [LOG2_W-1:0]  FW_MAX = 4'd10;
  localparam logic [LOG2_W-1:0]  LW_MIN = 4'd1;
  localparam logic [LOG2_W-1:0]  LW_MAX = 4'd12;
  localparam logic [BLOCK_W-1:0] BLOCKS_UNLIMITED = 16'hFFFF;

  localparam logic [LOG2_W-1:0]  RST_FETCH_WIDTH_LOG2 = 4'd2;
  localparam logic [LOG2_W-1:0]  RST_LINE_WORDS_LOG2  = 4'd4;
  localparam logic               RST_ALIGNED_FETCH    = 1'b1;
  localparam logic               RST_TRACE_ALIGN      = 1'b0;
  localparam logic               RST_TARGET_IN_LINE   = 1'b0;
  localparam logic               RST_FETCH_ONE_LINE   = 1'b1;
  localparam logic [SLOT_W-1:0]  RST_BLOCKS_PER_CYCLE = 11'd0;

  typedef enum logic [2:0] {
    REG_FETCH_WIDTH_LOG2 = 3'd0,
    REG_LINE_WORDS_LOG2  = 3'd1,
    REG_ALIGNED_FETCH    = 3'd2,
    REG_TRACE_ALIGN      = 3'd3,
    REG_TARGET_IN_LINE   = 3'd4,
    REG_FETCH_ONE_LINE   = 3'd5,
    REG_BLOCKS_PER_CYCLE = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_INSTR = 1'b0,
    OP_EMPTY = 1'b1
  } op_t;

endpackage

@@ src/fgf_ifs.sv @@
// Valid/ready channel interfaces for instruction events and group results.
// Depends on fgf_pkg for field widths.
interface fgf_in_if import fgf_pkg::*;;
  logic            valid;
  logic            ready;
  logic            op;
  logic [PC_W-1:0] pc;
  logic            is_control;
  logic            redirect;
  logic            has_target;

  modport source (output valid, op, pc, is_control, redirect, has_target, input ready);
  modport sink   (input valid, op, pc, is_control, redirect, has_target, output ready);
endinterface

interface fgf_out_if import fgf_pkg::*;;
  logic              valid;
  logic              ready;
  logic              consumed;
  logic              group_end;
  logic [SLOT_W-1:0] slots_lost;
  logic [SLOT_W-1:0] slots_remaining;

  modport source (output valid, consumed, group_end, slots_lost, slots_remaining, input ready);
  modport sink   (input valid, consumed, group_end, slots_lost, slots_remaining, output ready);
endinterface

@@ src/fetch_group_former_unit.sv @@
// Fetch group former: cuts instruction events into per-cycle fetch groups.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the sink accepts results; group state updates at the result register load.
// A full result register stalls the input register only when the sink holds ready low.
// Reset (rst, synchronous): no group open, state cleared, registers to defaults.
// Depends on fgf_pkg and the fgf_in_if / fgf_out_if interfaces.
module fetch_group_former_unit import fgf_pkg::*; #(
  parameter int unsigned PC_BITS = PC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  fgf_in_if.sink            item,
  fgf_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // configuration registers
  logic [LOG2_W-1:0] fetch_width_log2;
  logic [LOG2_W-1:0] line_words_log2;
  logic              aligned_fetch;
  logic              trace_align;
  logic              target_in_line;
  logic              fetch_one_line;
  logic [SLOT_W-1:0] blocks_per_cycle;

  cfg_reg_t cfg_sel;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_width_log2 <= RST_FETCH_WIDTH_LOG2;
      line_words_log2  <= RST_LINE_WORDS_LOG2;
      aligned_fetch    <= RST_ALIGNED_FETCH;
      trace_align      <= RST_TRACE_ALIGN;
      target_in_line   <= RST_TARGET_IN_LINE;
      fetch_one_line   <= RST_FETCH_ONE_LINE;
      blocks_per_cycle <= RST_BLOCKS_PER_CYCLE;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_FETCH_WIDTH_LOG2: fetch_width_log2 <= pwdata[LOG2_W-1:0];
        REG_LINE_WORDS_LOG2:  line_words_log2  <= pwdata[LOG2_W-1:0];
        REG_ALIGNED_FETCH:    aligned_fetch    <= pwdata[0];
        REG_TRACE_ALIGN:      trace_align      <= pwdata[0];
        REG_TARGET_IN_LINE:   target_in_line   <= pwdata[0];
        REG_FETCH_ONE_LINE:   fetch_one_line   <= pwdata[0];
        REG_BLOCKS_PER_CYCLE: blocks_per_cycle <= pwdata[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FETCH_WIDTH_LOG2: prdata = APB_DW'(fetch_width_log2);
      REG_LINE_WORDS_LOG2:  prdata = APB_DW'(line_words_log2);
      REG_ALIGNED_FETCH:    prdata = APB_DW'(aligned_fetch);
      REG_TRACE_ALIGN:      prdata = APB_DW'(trace_align);
      REG_TARGET_IN_LINE:   prdata = APB_DW'(target_in_line);
      REG_FETCH_ONE_LINE:   prdata = APB_DW'(fetch_one_line);
      REG_BLOCKS_PER_CYCLE: prdata = APB_DW'(blocks_per_cycle);
      default:              prdata = '0;
    endcase
  end

  // input register
  logic               s1_valid;
  logic               s1_op;
  logic [PC_BITS-1:0] s1_pc;
  logic               s1_ctl;
  logic               s1_redir;
  logic               s1_tgt;

  // result register
  logic              out_valid;
  logic              out_consumed;
  logic              out_end;
  logic [SLOT_W-1:0] out_lost;
  logic [SLOT_W-1:0] out_rem;

  // group state
  logic               group_open;
  logic [PC_BITS-1:0] previous_pc;
  logic [SLOT_W-1:0]  slot_budget;
  logic [BLOCK_W-1:0] block_budget;
  logic               delay_slot_pending;

  logic out_free;
  logic s1_fire;

  assign out_free   = !out_valid || result.ready;
  assign s1_fire    = s1_valid && out_free;
  assign item.ready = !s1_valid || out_free;

  assign result.valid           = out_valid;
  assign result.consumed        = out_consumed;
  assign result.group_end       = out_end;
  assign result.slots_lost      = out_lost;
  assign result.slots_remaining = out_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_op    <= item.op;
      s1_pc    <= item.pc[PC_BITS-1:0];
      s1_ctl   <= item.is_control;
      s1_redir <= item.redirect;
      s1_tgt   <= item.has_target;
    end
  end

  // group logic
  logic [LOG2_W-1:0]  wl;
  logic [LOG2_W-1:0]  ll;
  logic [SLOT_W-1:0]  w;
  logic [12:0]        l;
  logic [11:0]        epos;
  logic [12:0]        pos;
  logic [SLOT_W-1:0]  amask;
  logic [SLOT_W-1:0]  lost;
  logic [PC_BITS-1:0] p4;
  logic [PC_BITS-1:0] p8;
  logic               line_diff;
  logic               present;
  logic signed [12:0] budget;
  logic [BLOCK_W-1:0] bb;

  logic               n_consumed;
  logic               n_end;
  logic [SLOT_W-1:0]  n_lost;
  logic [SLOT_W-1:0]  n_rem;
  logic               group_open_next;
  logic [PC_BITS-1:0] previous_pc_next;
  logic [SLOT_W-1:0]  slot_budget_next;
  logic [BLOCK_W-1:0] block_budget_next;
  logic               delay_slot_pending_next;
  logic               refused;

  always_comb begin
    wl = fetch_width_log2;
    if (wl < FW_MIN) wl = FW_MIN;
    if (wl > FW_MAX) wl = FW_MAX;
    ll = line_words_log2;
    if (ll < LW_MIN) ll = LW_MIN;
    if (ll > LW_MAX) ll = LW_MAX;
  end

  assign w     = SLOT_W'(1) << wl;
  assign l     = 13'(1) << ll;
  assign epos  = s1_pc[13:2] & 12'(l - 13'd1);
  assign pos   = {1'b0, epos} + 13'(w);
  assign amask = aligned_fetch ? (w - SLOT_W'(1)) : ((w >> 1) - SLOT_W'(1));
  assign lost  = (SLOT_W'(s1_pc[11:2]) & amask) + ((pos > l) ? SLOT_W'(pos - l) : '0);
  assign p4    = previous_pc + PC_BITS'(4);
  assign p8    = previous_pc + PC_BITS'(8);
  assign line_diff = ((s1_pc ^ previous_pc) >> (ll + LOG2_W'(2))) != '0;
  assign present   = (s1_op == OP_INSTR);

  always_comb begin
    n_consumed              = 1'b0;
    n_end                   = 1'b0;
    n_lost                  = '0;
    n_rem                   = '0;
    group_open_next         = group_open;
    previous_pc_next        = previous_pc;
    slot_budget_next        = slot_budget;
    block_budget_next       = block_budget;
    delay_slot_pending_next = delay_slot_pending;
    budget                  = '0;
    bb                      = block_budget;
    refused                 = 1'b0;

    if (delay_slot_pending) begin
      delay_slot_pending_next = 1'b0;
      group_open_next         = 1'b0;
      n_end                   = 1'b1;
      if (present && s1_pc == p4) begin
        slot_budget_next = (slot_budget != '0) ? slot_budget - SLOT_W'(1) : '0;
        previous_pc_next = s1_pc;
        n_consumed       = 1'b1;
        n_rem            = slot_budget_next;
      end else begin
        n_rem = slot_budget;
      end
    end else if (!present) begin
      n_end           = group_open;
      n_rem           = group_open ? slot_budget : '0;
      group_open_next = 1'b0;
    end else begin
      if (!group_open) begin
        block_budget_next = (blocks_per_cycle != '0) ? BLOCK_W'(blocks_per_cycle)
                                                     : BLOCKS_UNLIMITED;
        n_lost = trace_align ? '0 : lost;
        budget = $signed(13'(w)) - $signed(13'(n_lost)) - 13'sd1;
      end else begin
        budget = $signed(13'(slot_budget));
        if (s1_pc == previous_pc) begin
          budget = budget;
        end else if (s1_pc == p4) begin
          budget = budget - 13'sd1;
        end else if (s1_pc != p8) begin
          if (!target_in_line || line_diff) begin
            if (bb != '0) bb = bb - BLOCK_W'(1);
          end
          block_budget_next = bb;
          if (bb == '0) refused = 1'b1;
          budget = budget - 13'sd1;
        end else begin
          budget = budget - 13'sd2;
        end
        if (fetch_one_line && line_diff) refused = 1'b1;
      end

      if (refused) begin
        group_open_next = 1'b0;
        n_end           = 1'b1;
        n_rem           = slot_budget;
      end else begin
        slot_budget_next = (budget < 0) ? '0 : SLOT_W'(budget);
        previous_pc_next = s1_pc;
        group_open_next  = 1'b1;
        n_consumed       = 1'b1;
        n_rem            = slot_budget_next;
        if (s1_ctl && s1_redir) begin
          if (s1_tgt && slot_budget_next != '0) begin
            delay_slot_pending_next = 1'b1;
          end else begin
            group_open_next = 1'b0;
            n_end           = 1'b1;
          end
        end else if (slot_budget_next == '0) begin
          group_open_next = 1'b0;
          n_end           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      group_open         <= 1'b0;
      previous_pc        <= '0;
      slot_budget        <= '0;
      block_budget       <= '0;
      delay_slot_pending <= 1'b0;
    end else if (s1_fire) begin
      out_valid          <= 1'b1;
      group_open         <= group_open_next;
      previous_pc        <= previous_pc_next;
      slot_budget        <= slot_budget_next;
      block_budget       <= block_budget_next;
      delay_slot_pending <= delay_slot_pending_next;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_consumed <= n_consumed;
      out_end      <= n_end;
      out_lost     <= n_lost;
      out_rem      <= n_rem;
    end
  end

endmodule

@@ src/fgf_checker.sv @@
// Port-level checks for fetch_group_former_unit, attached by bind.
// Depends on fgf_pkg and fetch_group_former_unit_assert.svh.
`include "fetch_group_former_unit_assert.svh"

module fgf_checker import fgf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic              consumed,
  input logic              group_end,
  input logic [SLOT_W-1:0] slots_lost,
  input logic [SLOT_W-1:0] slots_remaining
);

  `FGF_ASSERT_NEXT(a_hold_stalled, res_valid && !res_ready, res_valid && $stable(consumed) && $stable(group_end) && $stable(slots_remaining))
  `FGF_ASSERT_SAME(a_loss_only_on_join, res_valid && slots_lost != '0, consumed)
  `FGF_ASSERT_SAME(a_idle_no_group, res_valid && !consumed && !group_end, slots_remaining == '0)
  `FGF_ASSERT_SAME(a_open_has_slots, res_valid && consumed && !group_end, slots_remaining != '0)

endmodule

bind fetch_group_former_unit fgf_checker u_fgf_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (result.valid),
  .res_ready       (result.ready),
  .consumed        (result.consumed),
  .group_end       (result.group_end),
  .slots_lost      (result.slots_lost),
  .slots_remaining (result.slots_remaining)
);
